>>> hw/rtl/zbnsb_pkg.sv
// Shared types and constants for the zoned bitmap next-set-bit block.
`default_nettype none

package zbnsb_pkg;

   // Field widths of the request, response and register port.
   localparam int CMD_W      = 2;
   localparam int ZSEL_W     = 2;
   localparam int WIDX_W     = 10;
   localparam int VALUE_W    = 32;
   localparam int FRAME_W    = 32;
   localparam int ZCOUNT_W   = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // Register index as decoded from the register port address.
   localparam logic REG_ZONE_COUNT = 1'b0;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD   = 2'd0,
      CMD_BOUNDS = 2'd1,
      CMD_REWIND = 2'd2,
      CMD_NEXT   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ZONE,
      ST_READ,
      ST_LOOK,
      ST_DONE
   } state_type;

   // Access strobes from the sequencer to the bitmap memory.
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } ram_ctl_type;

endpackage

`default_nettype wire

>>> hw/rtl/zbnsb_channels.sv
// Valid/ready channel interfaces for requests and responses.
`default_nettype none

interface zbnsb_req_if;
   import zbnsb_pkg::*;

   logic                valid;
   logic                ready;
   cmd_type             cmd;
   logic [ZSEL_W-1:0]   zone_sel;
   logic [WIDX_W-1:0]   word_index;
   logic [VALUE_W-1:0]  word_value;
   logic [FRAME_W-1:0]  first_frame;
   logic [FRAME_W-1:0]  last_frame;

   modport source (
      output valid, cmd, zone_sel, word_index, word_value, first_frame, last_frame,
      input  ready
   );
   modport sink (
      input  valid, cmd, zone_sel, word_index, word_value, first_frame, last_frame,
      output ready
   );
endinterface

interface zbnsb_rsp_if;
   import zbnsb_pkg::*;

   logic                valid;
   logic                ready;
   logic [FRAME_W-1:0]  frame_number;
   logic                end_of_map;

   modport source (
      output valid, frame_number, end_of_map,
      input  ready
   );
   modport sink (
      input  valid, frame_number, end_of_map,
      output ready
   );
endinterface

`default_nettype wire

>>> hw/rtl/zoned_bitmap_next_set_bit.sv
// Top level: zoned page-frame bitmap with a find-next-set-bit iterator.
//
//  Channel   Direction  Handshake             Carries
//  -------   ---------  --------------------  ---------------------------------------------
//  req_ch    in         valid / ready         cmd, zone_sel, word_index, word_value, bounds
//  rsp_ch    out        valid / ready         frame_number, end_of_map
//  csr_*     in         APB write, pready=1   zone_count at byte address 0
//
// Load, bounds and rewind requests are carried out as they are taken, and the
// sequencer stays idle. A next request first works out the bit count of the zone
// under scan; then for each bitmap word read it addresses the bitmap memory and
// searches the returned word, a zone whose count the iterator has already reached
// takes one more step before the scan moves down a zone, and the answer is then
// loaded into the response register.
// Reset is synchronous and clears the bounds, the zone count and the iterator;
// the bitmap memory is not cleared and must be loaded before it is scanned.
// The finished response sits in an output register, so a stalled response
// only holds the block once a following next request has found its answer.
`default_nettype none

module zoned_bitmap_next_set_bit #(
   parameter int ZONES      = 4,
   parameter int WORD_BITS  = 32,
   parameter int ZONE_WORDS = 1024
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   zbnsb_req_if.sink                                req_ch,
   zbnsb_rsp_if.source                              rsp_ch,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [zbnsb_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [zbnsb_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic      [zbnsb_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                     csr_pready
);
   import zbnsb_pkg::*;

   localparam int ZIW   = (ZONES > 1) ? $clog2(ZONES) : 1;
   localparam int WCW   = $clog2(ZONE_WORDS + 1);
   localparam int OW    = $clog2(WORD_BITS);
   localparam int CAP   = ZONE_WORDS * WORD_BITS;
   localparam int PW    = $clog2(CAP + WORD_BITS);
   localparam int DEPTH = ZONES * ZONE_WORDS;
   localparam int AW    = $clog2(DEPTH);
   localparam int ZCW   = $clog2(ZONES + 1) + ZCOUNT_W;
   localparam int IXW   = $clog2(ZONE_WORDS + 1) + WIDX_W;

   // Control state.
   state_type               state_ff, state_in;
   logic [ZCOUNT_W-1:0]     zone_count_ff, zone_count_in;
   logic [ZIW-1:0]          scan_zone_ff, scan_zone_in;
   logic [WCW-1:0]          scan_word_ff, scan_word_in;
   logic [OW-1:0]           scan_off_ff, scan_off_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [FRAME_W-1:0]      zone_start_ff [ZONES];
   logic [FRAME_W-1:0]      zone_end_ff   [ZONES];

   // Payload registers.
   logic [PW-1:0]           nbits_ff, nbits_in;
   logic [FRAME_W-1:0]      res_frame_ff, res_frame_in;
   logic                    res_end_ff, res_end_in;
   logic [FRAME_W-1:0]      rsp_frame_ff, rsp_frame_in;
   logic                    rsp_end_ff, rsp_end_in;

   logic                    req_accept;
   logic                    cfg_we;
   logic [ZCOUNT_W-1:0]     count_sel;
   logic [ZCW-1:0]          count_wide;
   logic [ZCW-1:0]          n_use;
   logic [ZIW-1:0]          rewind_zone;
   logic                    zone_in_use;
   logic                    zsel_ok;
   logic                    widx_ok;
   logic                    bounds_we;
   logic [ZIW-1:0]          bounds_zone;
   logic [FRAME_W-1:0]      cur_start;
   logic [FRAME_W-1:0]      cur_end;
   logic [FRAME_W-1:0]      span;
   logic [PW-1:0]           nbits_calc;
   logic [PW-1:0]           word_base;
   logic [PW-1:0]           pos;
   logic [PW-1:0]           hit_idx;
   logic [WORD_BITS-1:0]    masked_word;
   logic                    bit_found;
   logic [OW-1:0]           bit_idx;
   logic                    zone_done;
   logic                    finish_end;

   ram_ctl_type             ram_ctl;
   logic [AW-1:0]           ram_waddr;
   logic [AW-1:0]           ram_raddr;
   logic [WORD_BITS-1:0]    ram_wdata;
   logic [WORD_BITS-1:0]    ram_rdata;

   // Requests are taken only while the sequencer is idle.
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_accept   = req_ch.valid && (state_ff == ST_IDLE);

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.frame_number = rsp_frame_ff;
   assign rsp_ch.end_of_map   = rsp_end_ff;

   // Register port: a write completes in its access phase, there are no wait states.
   assign csr_pready = 1'b1;
   assign cfg_we     = csr_psel && csr_penable && csr_pwrite
                       && (csr_paddr[CSR_ADDR_W-1] == REG_ZONE_COUNT);
   assign csr_prdata = (csr_paddr[CSR_ADDR_W-1] == REG_ZONE_COUNT)
                       ? CSR_DATA_W'(zone_count_ff) : '0;

   // Zones in use, capped at the number built. A register write rewinds the
   // iterator against the newly written count.
   assign count_sel   = cfg_we ? csr_pwdata[ZCOUNT_W-1:0] : zone_count_ff;
   assign count_wide  = ZCW'(count_sel);
   assign n_use       = (count_wide > ZCW'(ZONES)) ? ZCW'(ZONES) : count_wide;
   assign rewind_zone = (n_use == '0) ? '0 : ZIW'(n_use - ZCW'(1));
   assign zone_in_use = ZCW'(scan_zone_ff) < n_use;

   // Request field checks: commands aimed outside the built store are dropped.
   assign zsel_ok     = ZCW'(req_ch.zone_sel) < ZCW'(ZONES);
   assign widx_ok     = IXW'(req_ch.word_index) < IXW'(ZONE_WORDS);
   assign bounds_zone = ZIW'(req_ch.zone_sel);

   // Bit count of the zone under scan: empty when the end is not above the
   // start, and never more than one zone's worth of bitmap.
   assign cur_start  = zone_start_ff[scan_zone_ff];
   assign cur_end    = zone_end_ff[scan_zone_ff];
   assign span       = cur_end - cur_start;
   assign nbits_calc = (cur_end <= cur_start) ? '0
                       : (span > FRAME_W'(CAP)) ? PW'(CAP) : PW'(span);

   // Iterator position as a bit index; the offset is only non-zero for the
   // first word searched after a hit.
   assign word_base = PW'(scan_word_ff) * PW'(WORD_BITS);
   assign pos       = word_base + PW'(scan_off_ff);
   assign hit_idx   = word_base + PW'(bit_idx);

   assign masked_word = ram_rdata & ({WORD_BITS{1'b1}} << scan_off_ff);

   assign ram_waddr = AW'(bounds_zone) * AW'(ZONE_WORDS) + AW'(req_ch.word_index);
   assign ram_raddr = AW'(scan_zone_ff) * AW'(ZONE_WORDS) + AW'(scan_word_ff);
   assign ram_wdata = WORD_BITS'(req_ch.word_value);

   zbnsb_ram #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .DW    (WORD_BITS)
   ) u_ram (
      .clock (clock),
      .ctl   (ram_ctl),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   zbnsb_lowbit #(
      .W  (WORD_BITS),
      .IW (OW)
   ) u_lowbit (
      .word  (masked_word),
      .found (bit_found),
      .index (bit_idx)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Sequencer: a next request checks the zone, then alternates between
   // addressing a bitmap word and searching it, stepping down through the
   // zones until a set bit turns up or zone 0 runs out.
   always_comb begin
      state_in      = state_ff;
      zone_count_in = zone_count_ff;
      scan_zone_in  = scan_zone_ff;
      scan_word_in  = scan_word_ff;
      scan_off_in   = scan_off_ff;
      nbits_in      = nbits_ff;
      res_frame_in  = res_frame_ff;
      res_end_in    = res_end_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_frame_in  = rsp_frame_ff;
      rsp_end_in    = rsp_end_ff;
      ram_ctl       = '0;
      bounds_we     = 1'b0;
      zone_done     = 1'b0;
      finish_end    = 1'b0;

      if (cfg_we) begin
         zone_count_in = csr_pwdata[ZCOUNT_W-1:0];
         scan_zone_in  = rewind_zone;
         scan_word_in  = '0;
         scan_off_in   = '0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (req_ch.cmd)
                  CMD_LOAD: begin
                     ram_ctl.wr_en = zsel_ok && widx_ok;
                  end
                  CMD_BOUNDS: begin
                     bounds_we = zsel_ok;
                  end
                  CMD_REWIND: begin
                     scan_zone_in = rewind_zone;
                     scan_word_in = '0;
                     scan_off_in  = '0;
                  end
                  CMD_NEXT: begin
                     state_in = ST_ZONE;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_ZONE: begin
            if (!zone_in_use) begin
               finish_end = 1'b1;
            end else begin
               nbits_in = nbits_calc;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (pos >= nbits_ff) begin
               zone_done = 1'b1;
            end else begin
               ram_ctl.rd_en = 1'b1;
               state_in      = ST_LOOK;
            end
         end
         ST_LOOK: begin
            if (bit_found) begin
               if (hit_idx < nbits_ff) begin
                  res_frame_in = cur_start + FRAME_W'(hit_idx);
                  res_end_in   = 1'b0;
                  if (bit_idx == OW'(WORD_BITS - 1)) begin
                     scan_word_in = scan_word_ff + WCW'(1);
                     scan_off_in  = '0;
                  end else begin
                     scan_off_in  = bit_idx + OW'(1);
                  end
                  state_in = ST_DONE;
               end else begin
                  zone_done = 1'b1;
               end
            end else begin
               scan_word_in = scan_word_ff + WCW'(1);
               scan_off_in  = '0;
               state_in     = ST_READ;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_frame_in = res_frame_ff;
               rsp_end_in   = res_end_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // The zone under scan holds no further set bit: step down a zone, or
      // give the end marker once zone 0 is spent.
      if (zone_done) begin
         if (scan_zone_ff == '0) begin
            finish_end = 1'b1;
         end else begin
            scan_zone_in = scan_zone_ff - ZIW'(1);
            scan_word_in = '0;
            scan_off_in  = '0;
            state_in     = ST_ZONE;
         end
      end

      // The end marker also rewinds the iterator.
      if (finish_end) begin
         scan_zone_in = rewind_zone;
         scan_word_in = '0;
         scan_off_in  = '0;
         res_frame_in = '0;
         res_end_in   = 1'b1;
         state_in     = ST_DONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zone_count_ff <= '0;
         scan_zone_ff  <= '0;
         scan_word_ff  <= '0;
         scan_off_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         zone_count_ff <= zone_count_in;
         scan_zone_ff  <= scan_zone_in;
         scan_word_ff  <= scan_word_in;
         scan_off_ff   <= scan_off_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      nbits_ff     <= nbits_in;
      res_frame_ff <= res_frame_in;
      res_end_ff   <= res_end_in;
      rsp_frame_ff <= rsp_frame_in;
      rsp_end_ff   <= rsp_end_in;
   end

   // Zone bounds live in flip-flops so that reset can clear them at once.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int z = 0; z < ZONES; z++) begin
            zone_start_ff[z] <= '0;
            zone_end_ff[z]   <= '0;
         end
      end else if (bounds_we) begin
         zone_start_ff[bounds_zone] <= req_ch.first_frame;
         zone_end_ff[bounds_zone]   <= req_ch.last_frame;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/zbnsb_ram.sv
// Bitmap word memory: one write port, one read port with registered data.
`default_nettype none

module zbnsb_ram #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12,
   parameter int DW    = 32
) (
   input  wire logic                   clock,
   input  wire zbnsb_pkg::ram_ctl_type ctl,
   input  wire logic [AW-1:0]          waddr,
   input  wire logic [DW-1:0]          wdata,
   input  wire logic [AW-1:0]          raddr,
   output logic      [DW-1:0]          rdata
);
   import zbnsb_pkg::*;

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[waddr] <= wdata;
      end
      if (ctl.rd_en) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

>>> hw/rtl/zbnsb_lowbit.sv
// Finds the index of the lowest set bit of a bitmap word.
`default_nettype none

module zbnsb_lowbit #(
   parameter int W  = 32,
   parameter int IW = $clog2(W)
) (
   input  wire logic [W-1:0]  word,
   output logic               found,
   output logic [IW-1:0]      index
);
   import zbnsb_pkg::*;

   logic [W-1:0] lowest;

   // Two's complement trick leaves only the lowest set bit standing.
   assign lowest = word & (~word + W'(1));
   assign found  = |word;

   always_comb begin
      index = '0;
      for (int i = 0; i < W; i++) begin
         if (lowest[i]) begin
            index = index | IW'(i);
         end
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/zbnsb_checker.sv
// Port-level assertions for the zoned bitmap block, bound to its top level.
`default_nettype none

module zbnsb_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_valid,
   input wire logic                        req_ready,
   input wire zbnsb_pkg::cmd_type          req_cmd,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire logic [zbnsb_pkg::FRAME_W-1:0] rsp_frame_number,
   input wire logic                        rsp_end_of_map
);
   import zbnsb_pkg::*;

   logic       next_taken;
   logic       rsp_taken;
   logic [1:0] pending_ff;

   assign next_taken = req_valid && req_ready && (req_cmd == CMD_NEXT);
   assign rsp_taken  = rsp_valid && rsp_ready;

   // Next requests accepted whose response has not yet been taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_ff + 2'(next_taken) - 2'(rsp_taken);
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_frame_number)
                                 && $stable(rsp_end_of_map))
      else $error("response changed while stalled");

   a_end_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_of_map |-> rsp_frame_number == '0)
      else $error("end marker carries a non-zero frame number");

   a_rsp_owed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 2'd0)
      else $error("response without an outstanding next request");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid straight after reset");

endmodule

bind zoned_bitmap_next_set_bit zbnsb_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .req_cmd          (req_ch.cmd),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_frame_number (rsp_ch.frame_number),
   .rsp_end_of_map   (rsp_ch.end_of_map)
);

`default_nettype wire

>>> test/zoned_bitmap_next_set_bit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the zoned bitmap next-set-bit block.

module zoned_bitmap_next_set_bit_tb;
   import zbnsb_pkg::*;

   localparam int ZONES      = 4;
   localparam int WORD_BITS  = 32;
   localparam int ZONE_WORDS = 1024;
   // A zone never holds more bits than its page of bitmap words.
   localparam int unsigned ZONE_CAP = ZONE_WORDS * WORD_BITS;

   // Register i sits at byte address 4*i; index 1 is not decoded.
   localparam logic [CSR_ADDR_W-1:0] ZONE_COUNT_ADDR = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] UNMAPPED_ADDR   = 3'd4;

   // Load, bounds and rewind requests finish as they are taken, so a short pause
   // after the last response is enough to be sure the block is idle.
   localparam int SETTLE_CYCLES  = 8;
   localparam int PHASE_REQUESTS = 85;
   localparam int unsigned CYCLE_LIMIT = 3_000_000;

   typedef struct {
      cmd_type             cmd;
      logic [ZSEL_W-1:0]   zone_sel;
      logic [WIDX_W-1:0]   word_index;
      logic [VALUE_W-1:0]  word_value;
      logic [FRAME_W-1:0]  first_frame;
      logic [FRAME_W-1:0]  last_frame;
   } frame_req_t;

   typedef struct {
      logic [FRAME_W-1:0]  frame_number;
      logic                end_of_map;
   } frame_hit_t;

   // One line of the directed script: either a register write or a request,
   // the latter optionally with its answer written out by hand.
   typedef struct {
      bit                      reg_write;
      logic [CSR_ADDR_W-1:0]   reg_addr;
      logic [CSR_DATA_W-1:0]   reg_data;
      frame_req_t              req;
      bit                      typed;
      frame_hit_t              want;
   } script_row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always #5 clock = ~clock;

   zbnsb_req_if req_if ();
   zbnsb_rsp_if rsp_if ();

   logic                   csr_sel    = 1'b0;
   logic                   csr_enable = 1'b0;
   logic                   csr_write  = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_addr   = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;
   logic [CSR_DATA_W-1:0]  csr_rdata;
   logic                   csr_ready;
   logic                   rsp_accept = 1'b0;

   assign rsp_if.ready = rsp_accept;

   zoned_bitmap_next_set_bit #(
      .ZONES      (ZONES),
      .WORD_BITS  (WORD_BITS),
      .ZONE_WORDS (ZONE_WORDS)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_if),
      .rsp_ch      (rsp_if),
      .csr_psel    (csr_sel),
      .csr_penable (csr_enable),
      .csr_pwrite  (csr_write),
      .csr_paddr   (csr_addr),
      .csr_pwdata  (csr_wdata),
      .csr_prdata  (csr_rdata),
      .csr_pready  (csr_ready)
   );

   // Our own copy of the block's state. The bitmap copy is only ever read at
   // words that have been loaded, which word_loaded keeps track of.
   logic [WORD_BITS-1:0]  bitmap_copy [ZONES][ZONE_WORDS];
   bit                    word_loaded [ZONES][ZONE_WORDS];
   logic [FRAME_W-1:0]    copy_start  [ZONES];
   logic [FRAME_W-1:0]    copy_end    [ZONES];
   logic [ZCOUNT_W-1:0]   copy_zone_count;
   int unsigned           iter_zone;
   int unsigned           iter_bit;

   frame_hit_t   frames_due [$];
   frame_hit_t   no_hit;
   script_row_t  script [$];
   int           fail_count = 0;
   int unsigned  cycle_count = 0;
   int unsigned  burst_left = 0;
   int unsigned  stall_left = 0;

   // Counts above the number of zones saturate.
   function automatic int unsigned zones_live();
      return (copy_zone_count > ZONES) ? ZONES : copy_zone_count;
   endfunction

   // The iterator restarts at the highest zone in use, bit zero.
   function automatic void rewind_iterator();
      int unsigned n;
      n = zones_live();
      iter_zone = (n != 0) ? n - 1 : 0;
      iter_bit  = 0;
   endfunction

   function automatic void set_zone_count(input logic [ZCOUNT_W-1:0] value);
      copy_zone_count = value;
      rewind_iterator();
   endfunction

   // Number of valid bits in a zone: end minus start, none when the end does
   // not lie above the start, and never more than the zone's capacity.
   function automatic int unsigned zone_span(input int unsigned z);
      logic [FRAME_W-1:0] span;
      if (copy_end[z] <= copy_start[z])
         return 0;
      span = copy_end[z] - copy_start[z];
      return (span > ZONE_CAP) ? ZONE_CAP : span;
   endfunction

   // Lowest set bit of zone z with an index in [from, nbits), else nbits.
   function automatic int unsigned first_set_bit(input int unsigned z,
                                                 input int unsigned from,
                                                 input int unsigned nbits);
      int unsigned w;
      int unsigned idx;
      logic [WORD_BITS-1:0] bits;
      if (from >= nbits)
         return nbits;
      for (w = from / WORD_BITS; w < ZONE_WORDS && w * WORD_BITS < nbits; w++) begin
         bits = bitmap_copy[z][w];
         if (w == from / WORD_BITS)
            bits = bits & ({WORD_BITS{1'b1}} << (from % WORD_BITS));
         for (int i = 0; i < WORD_BITS; i++) begin
            if (bits[i]) begin
               idx = w * WORD_BITS + i;
               return (idx < nbits) ? idx : nbits;
            end
         end
      end
      return nbits;
   endfunction

   // Follows the words that the next scan will read, without moving the
   // iterator, and reports the first of them that has never been loaded.
   function automatic bit unloaded_on_path(output int unsigned zo,
                                           output int unsigned wo);
      int unsigned z;
      int unsigned from;
      int unsigned nbits;
      int unsigned w;
      int unsigned lo;
      int unsigned hi;
      z    = iter_zone;
      from = iter_bit;
      zo   = 0;
      wo   = 0;
      while (z < zones_live()) begin
         nbits = zone_span(z);
         w     = from / WORD_BITS;
         while (from < nbits && w * WORD_BITS < nbits) begin
            if (!word_loaded[z][w]) begin
               zo = z;
               wo = w;
               return 1'b1;
            end
            lo = (w * WORD_BITS > from) ? w * WORD_BITS : from;
            hi = ((w + 1) * WORD_BITS < nbits) ? (w + 1) * WORD_BITS : nbits;
            if (first_set_bit(z, lo, hi) < hi)
               return 1'b0;
            w++;
         end
         if (z == 0)
            break;
         z--;
         from = 0;
      end
      return 1'b0;
   endfunction

   // Works out the answer to a next request and moves the iterator on. An
   // exhausted zone hands over to the one below it; once zone zero is spent
   // the end marker comes back and the iterator starts again.
   function automatic frame_hit_t find_next_frame();
      frame_hit_t  hit;
      int unsigned nbits;
      int unsigned idx;
      while (iter_zone < zones_live()) begin
         nbits = zone_span(iter_zone);
         idx   = first_set_bit(iter_zone, iter_bit, nbits);
         if (idx < nbits) begin
            iter_bit         = idx + 1;
            hit.frame_number = copy_start[iter_zone] + idx;
            hit.end_of_map   = 1'b0;
            return hit;
         end
         if (iter_zone == 0)
            break;
         iter_zone--;
         iter_bit = 0;
      end
      rewind_iterator();
      hit.frame_number = '0;
      hit.end_of_map   = 1'b1;
      return hit;
   endfunction

   // Applies one accepted request to the copy of the state. Returns 1 when
   // the request produces a response, which is then left in hit.
   function automatic bit apply_request(input frame_req_t r, output frame_hit_t hit);
      hit.frame_number = '0;
      hit.end_of_map   = 1'b0;
      case (r.cmd)
         CMD_LOAD: begin
            bitmap_copy[r.zone_sel][r.word_index] = r.word_value;
            word_loaded[r.zone_sel][r.word_index] = 1'b1;
         end
         CMD_BOUNDS: begin
            copy_start[r.zone_sel] = r.first_frame;
            copy_end[r.zone_sel]   = r.last_frame;
         end
         CMD_REWIND: begin
            rewind_iterator();
         end
         default: begin
            hit = find_next_frame();
            return 1'b1;
         end
      endcase
      return 1'b0;
   endfunction

   // Bitmap contents lean towards empty and single-bit words so that scans
   // cross several words and zones before they hit.
   function automatic logic [WORD_BITS-1:0] bitmap_word();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return '0;
         5, 6:          return {{(WORD_BITS-1){1'b0}}, 1'b1} << $urandom_range(0, WORD_BITS-1);
         default:       return $urandom();
      endcase
   endfunction

   // Every field carries random bits whatever the command, so that each bit
   // of every field is seen in both states.
   function automatic frame_req_t random_request();
      frame_req_t  r;
      int unsigned pick;
      r.cmd         = CMD_NEXT;
      r.zone_sel    = ZSEL_W'($urandom_range(0, ZONES-1));
      r.word_index  = WIDX_W'($urandom());
      r.word_value  = $urandom();
      r.first_frame = $urandom();
      r.last_frame  = $urandom();
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
         r.cmd = CMD_NEXT;
      end else if (pick < 72) begin
         // Most loads land in the first few words, which is where the scans run.
         r.cmd        = CMD_LOAD;
         r.word_index = WIDX_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, ZONE_WORDS-1)
                                                            : $urandom_range(0, 11));
         r.word_value = bitmap_word();
      end else if (pick < 88) begin
         r.cmd = CMD_BOUNDS;
         if ($urandom_range(0, 39) == 0) begin
            // A rare zone far larger than its capacity.
            r.first_frame = $urandom_range(0, 32'h7FFF_FFFF);
            r.last_frame  = r.first_frame + $urandom_range(ZONE_CAP, 32'h7FFF_FFFF);
         end else if ($urandom_range(0, 7) == 0) begin
            // End at or below the start: a zone without bits.
            r.last_frame = r.first_frame - $urandom_range(0, 64);
         end else begin
            r.last_frame = r.first_frame + $urandom_range(1, 320);
         end
      end else begin
         r.cmd = CMD_REWIND;
      end
      return r;
   endfunction

   // Presents one request and holds it until the block takes it. The sender
   // runs in bursts; between bursts valid drops for a random number of cycles,
   // and now and then a burst follows straight on from the last.
   task automatic send_request(input frame_req_t r, input bit typed, input frame_hit_t want);
      frame_hit_t  got;
      bit          took;
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_if.valid       <= 1'b1;
      req_if.cmd         <= r.cmd;
      req_if.zone_sel    <= r.zone_sel;
      req_if.word_index  <= r.word_index;
      req_if.word_value  <= r.word_value;
      req_if.first_frame <= r.first_frame;
      req_if.last_frame  <= r.last_frame;
      // Ready is looked at on the falling edge, where it has long settled,
      // and the request counts as taken at the rising edge that follows.
      do begin
         @(negedge clock);
         took = req_if.ready;
         @(posedge clock);
      end while (!took);
      if (apply_request(r, got))
         frames_due.push_back(typed ? want : got);
   endtask

   // Stops sending, waits for every outstanding response and then lets the
   // block settle, so that registers are only written while it is idle.
   task automatic drain_requests();
      req_if.valid <= 1'b0;
      while (frames_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register write: a setup phase, then the access phase held until pready.
   task automatic write_register(input logic [CSR_ADDR_W-1:0] addr,
                                 input logic [CSR_DATA_W-1:0] data);
      bit done;
      csr_sel    <= 1'b1;
      csr_enable <= 1'b0;
      csr_write  <= 1'b1;
      csr_addr   <= addr;
      csr_wdata  <= data;
      @(posedge clock);
      csr_enable <= 1'b1;
      do begin
         @(negedge clock);
         done = csr_ready;
         @(posedge clock);
      end while (!done);
      csr_sel    <= 1'b0;
      csr_enable <= 1'b0;
      if (addr == ZONE_COUNT_ADDR)
         set_zone_count(data[ZCOUNT_W-1:0]);
   endtask

   // The bitmap memory is not cleared by reset, so before a next request each
   // word that its scan will read gets loaded first. A freshly loaded word may
   // end the scan early, so the path is followed again after every load.
   task automatic preload_scan_words();
      frame_req_t  fill;
      int unsigned z;
      int unsigned w;
      while (unloaded_on_path(z, w)) begin
         fill            = random_request();
         fill.cmd        = CMD_LOAD;
         fill.zone_sel   = z[ZSEL_W-1:0];
         fill.word_index = w[WIDX_W-1:0];
         fill.word_value = bitmap_word();
         send_request(fill, 1'b0, no_hit);
      end
   endtask

   function automatic void add_row(input bit reg_write, input cmd_type cmd,
                                   input logic [ZSEL_W-1:0] zsel,
                                   input logic [31:0] a, input logic [31:0] b,
                                   input logic [31:0] c, input bit typed,
                                   input logic [FRAME_W-1:0] frame, input logic at_end);
      script_row_t row;
      row.reg_write          = reg_write;
      row.reg_addr           = a[CSR_ADDR_W-1:0];
      row.reg_data           = b;
      row.req.cmd            = cmd;
      row.req.zone_sel       = zsel;
      row.req.word_index     = a[WIDX_W-1:0];
      row.req.word_value     = b;
      row.req.first_frame    = b;
      row.req.last_frame     = c;
      row.typed              = typed;
      row.want.frame_number  = frame;
      row.want.end_of_map    = at_end;
      script.push_back(row);
   endfunction

   // Directed script. Register rows give the address in a and the data in b;
   // loads give the word index in a and the word in b; bounds give the start
   // in b and the end in c. Rows with typed set carry their answer by hand.
   initial begin
      // After reset no zone is in use, so the first answer is the end marker.
      add_row(0, CMD_NEXT,   0, 0, 0, 0, 1, 32'h0, 1'b1);
      add_row(0, CMD_BOUNDS, 0, 0, 32'h0000_0100, 32'h0000_0140, 0, 0, 0);
      add_row(0, CMD_LOAD,   0, 0, 32'h8000_0001, 0, 0, 0, 0);
      add_row(0, CMD_LOAD,   0, 1, 32'h0000_0000, 0, 0, 0, 0);
      add_row(0, CMD_REWIND, 0, 0, 0, 0, 0, 0, 0);
      add_row(0, CMD_NEXT,   0, 0, 0, 0, 1, 32'h0, 1'b1);
      // One zone in use: both set bits of zone zero, then the end marker, and
      // then the iterator starts from the top once more.
      add_row(1, CMD_REWIND, 0, ZONE_COUNT_ADDR, 32'h1, 0, 0, 0, 0);
      add_row(0, CMD_NEXT,   0, 0, 0, 0, 1, 32'h0000_0100, 1'b0);
      add_row(0, CMD_NEXT,   0, 0, 0, 0, 1, 32'h0000_011F, 1'b0);
      add_row(0, CMD_NEXT,   0, 0, 0, 0, 1, 32'h0, 1'b1);
      add_row(0, CMD_NEXT,   0, 0, 0, 0, 1, 32'h0000_0100, 1'b0);
      add_row(0, CMD_REWIND, 0, 0, 0, 0, 0, 0, 0);
      add_row(0, CMD_NEXT,   0, 0, 0, 0, 1, 32'h0000_0100, 1'b0);
      // Zone one sits at the top of the frame space, zone two ends below its
      // start and zone three is empty, with its last word loaded all ones.
      add_row(0, CMD_BOUNDS, 1, 0, 32'hFFFF_FFE0, 32'hFFFF_FFFF, 0, 0, 0);
      add_row(0, CMD_LOAD,   1, 0, 32'hFFFF_FFFF, 0, 0, 0, 0);
      add_row(0, CMD_BOUNDS, 2, 0, 32'h0000_0050, 32'h0000_0010, 0, 0, 0);
      add_row(0, CMD_BOUNDS, 3, 0, 32'h0000_0000, 32'h0000_0000, 0, 0, 0);
      add_row(0, CMD_LOAD,   3, ZONE_WORDS-1, 32'hFFFF_FFFF, 0, 0, 0, 0);
      // A count of seven saturates at four zones; the scan falls through the
      // two empty zones into zone one.
      add_row(1, CMD_REWIND, 0, ZONE_COUNT_ADDR, 32'h7, 0, 0, 0, 0);
      add_row(0, CMD_NEXT,   0, 0, 0, 0, 1, 32'hFFFF_FFE0, 1'b0);
      add_row(0, CMD_NEXT,   0, 0, 0, 0, 0, 0, 0);
      // Shrinking zone one leaves the iterator beyond its bit count.
      add_row(0, CMD_BOUNDS, 1, 0, 32'hFFFF_FFE0, 32'hFFFF_FFE1, 0, 0, 0);
      add_row(0, CMD_NEXT,   0, 0, 0, 0, 0, 0, 0);
      // A write to an undecoded address must leave the iterator alone.
      add_row(1, CMD_REWIND, 0, UNMAPPED_ADDR, 32'hFFFF_FFFF, 0, 0, 0, 0);
      add_row(0, CMD_NEXT,   0, 0, 0, 0, 0, 0, 0);
      add_row(1, CMD_REWIND, 0, ZONE_COUNT_ADDR, 32'h0, 0, 0, 0, 0);
      add_row(0, CMD_NEXT,   0, 0, 0, 0, 1, 32'h0, 1'b1);
   end

   // Main stimulus: reset, the directed script, then random phases, each
   // opened by a fresh zone count written while the block is idle.
   initial begin : stimulus
      logic [ZCOUNT_W-1:0] zone_plan [8];
      frame_req_t          r;
      zone_plan = '{3'd4, 3'd1, 3'd7, 3'd2, 3'd0, 3'd3, 3'd5, 3'd4};
      no_hit.frame_number = '0;
      no_hit.end_of_map   = 1'b0;
      req_if.valid       <= 1'b0;
      req_if.cmd         <= CMD_LOAD;
      req_if.zone_sel    <= '0;
      req_if.word_index  <= '0;
      req_if.word_value  <= '0;
      req_if.first_frame <= '0;
      req_if.last_frame  <= '0;
      for (int z = 0; z < ZONES; z++) begin
         copy_start[z] = '0;
         copy_end[z]   = '0;
         for (int w = 0; w < ZONE_WORDS; w++) begin
            bitmap_copy[z][w] = '0;
            word_loaded[z][w] = 1'b0;
         end
      end
      set_zone_count('0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (script[k]) begin
         if (script[k].reg_write) begin
            drain_requests();
            write_register(script[k].reg_addr, script[k].reg_data);
         end else begin
            if (script[k].req.cmd == CMD_NEXT)
               preload_scan_words();
            send_request(script[k].req, script[k].typed, script[k].want);
         end
      end

      // Random phases. The upper data bits of the register write are random;
      // only the low bits hold the count.
      foreach (zone_plan[p]) begin
         drain_requests();
         write_register(ZONE_COUNT_ADDR, ($urandom() & ~32'h7) | zone_plan[p]);
         for (int n = 0; n < PHASE_REQUESTS; n++) begin
            r = random_request();
            // Every so often the sender waits for the block to empty out.
            if ($urandom_range(0, 59) == 0)
               drain_requests();
            if (r.cmd == CMD_NEXT)
               preload_scan_words();
            send_request(r, 1'b0, no_hit);
         end
      end

      drain_requests();
      repeat (4 * SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // The receiver alternates, with bit 8 of the cycle count, between stretches in which it
   // always accepts and stretches in which it stalls at random.
   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_accept <= 1'b0;
         stall_left--;
      end else begin
         rsp_accept <= 1'b1;
         if (cycle_count[8] && $urandom_range(0, 2) == 0)
            stall_left = $urandom_range(1, 14);
      end
   end

   // Responses are checked on the falling edge before the rising edge that
   // takes them, against the oldest outstanding expectation.
   always @(negedge clock) begin : check_frames
      frame_hit_t want;
      if (!reset && rsp_if.valid && rsp_accept) begin
         if (frames_due.size() == 0) begin
            $error("unexpected response: frame_number %h, end_of_map %b",
                   rsp_if.frame_number, rsp_if.end_of_map);
            fail_count++;
         end else begin
            want = frames_due.pop_front();
            if (rsp_if.frame_number !== want.frame_number) begin
               $error("frame_number: expected %h, actual %h",
                      want.frame_number, rsp_if.frame_number);
               fail_count++;
            end
            if (rsp_if.end_of_map !== want.end_of_map) begin
               $error("end_of_map: expected %b, actual %b",
                      want.end_of_map, rsp_if.end_of_map);
               fail_count++;
            end
         end
      end
   end

   // Watchdog against a hung handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

endmodule

>>> zoned_bitmap_next_set_bit.f
hw/rtl/zbnsb_pkg.sv
hw/rtl/zbnsb_channels.sv
hw/rtl/zbnsb_ram.sv
hw/rtl/zbnsb_lowbit.sv
hw/rtl/zoned_bitmap_next_set_bit.sv
hw/rtl/zbnsb_checker.sv
test/zoned_bitmap_next_set_bit_tb.sv
